### hw/rtl/mcstb_pkg.sv
// ----------------------------------------------------------------------------
// mcstb_pkg
// Shared types and constants for the soft timer bank.
// ----------------------------------------------------------------------------
package mcstb_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_CREATE = 2'd1,
        OP_START  = 2'd2,
        OP_STOP   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_WALK,
        ST_ACK
    } state_t;

    // One timer slot as held in the slot memory
    typedef struct packed {
        logic        created;
        logic [1:0]  ttype;
        logic [31:0] timeout;
        logic [31:0] start;
    } slot_t;

    localparam logic       KIND_ACK    = 1'b0;
    localparam logic       KIND_EXPIRY = 1'b1;
    localparam logic [9:0] MS_PER_SEC  = 10'd1000;

    // Types 0 and 2 count in seconds, 1 and 3 in milliseconds
    function automatic logic is_sec_type(input logic [1:0] t);
        return !t[0];
    endfunction

    // Types 2 and 3 reload on expiry
    function automatic logic is_periodic(input logic [1:0] t);
        return t[1];
    endfunction

endpackage

### hw/rtl/multi_channel_soft_timer_bank_top.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank_top
// Bank of one-shot and periodic millisecond timers kept in a slot memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one operation: tick, create,
// start or stop. Output channel (out_valid/out_ready) returns, per item,
// the expiry events of a tick in slot order and then one acknowledge with
// last set.
// Create, start and stop do one read-modify-write of their slot: read in
// ST_RD, write in ST_MOD, then the acknowledge is loaded in ST_ACK once the
// output register is free, and the next item is taken on the cycle after that.
// A tick with a new time walks every slot through the memory read port, one
// slot per cycle while expiries find the output register free, with read and
// write-back overlapped. A tick that repeats the previous time, and a create,
// start or stop on a slot beyond the bank, go straight to the acknowledge.
// The single memory read port sets the walk rate.
// A stalled receiver holds the walk on any expiry that finds the output
// register full; slots that do not fire keep moving.
// Reset clears the per-slot valid bits, so every slot reads as stopped and
// not created; there is no clearing pass and items are taken straight away.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_top #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               opcode,
    input  logic [4:0]               timer_index,
    input  logic [1:0]               timer_type,
    input  logic [31:0]              timeout_value,
    input  logic [31:0]              now_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     kind,
    output logic [3:0]               fired_timer,
    output logic                     ok,
    output logic                     last
);
    import mcstb_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] WALK_END  = CW'(NUM_TIMERS);
    localparam logic [5:0]    IDX_LIMIT = 6'(NUM_TIMERS);

    // control and item registers
    state_t        state_reg,     state_next;
    opcode_t       op_reg,        op_next;
    logic [4:0]    idx_reg,       idx_next;
    logic [1:0]    typ_reg,       typ_next;
    logic [31:0]   tval_reg,      tval_next;
    logic [31:0]   tval_sec_reg,  tval_sec_next;
    logic [31:0]   cur_time_reg,  cur_time_next;
    logic [31:0]   prev_tick_reg, prev_tick_next;
    logic          ack_ok_reg,    ack_ok_next;
    logic [CW-1:0] walk_rd_reg,   walk_rd_next;
    logic          eval_v_reg,    eval_v_next;
    logic [AW-1:0] eval_addr_reg, eval_addr_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic          kind_reg,      kind_next;
    logic [3:0]    fired_reg,     fired_next;
    logic          ok_reg,        ok_next;
    logic          last_reg,      last_next;

    // slot memory
    slot_t                 mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] vld_reg;
    slot_t                 rd_entry_reg;
    logic                  rd_vld_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    slot_t                 wr_entry;

    slot_t       cur;
    logic [31:0] elapsed;
    logic        expired;
    logic        emit;
    logic        out_free;
    logic        idx_in_range;
    logic [41:0] tval_prod;

    assign cur       = rd_vld_reg ? rd_entry_reg : '0;
    assign elapsed   = cur_time_reg - cur.start;
    assign expired   = (cur.timeout != 32'd0) && !(elapsed < cur.timeout);
    assign emit      = eval_v_reg && expired && cur.created;
    assign out_free  = !out_valid_reg || out_ready;
    assign tval_prod = timeout_value * MS_PER_SEC;
    assign idx_in_range = {1'b0, timer_index} < IDX_LIMIT;

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign fired_timer = fired_reg;
    assign ok          = ok_reg;
    assign last        = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        typ_next       = typ_reg;
        tval_next      = tval_reg;
        tval_sec_next  = tval_sec_reg;
        cur_time_next  = cur_time_reg;
        prev_tick_next = prev_tick_reg;
        ack_ok_next    = ack_ok_reg;
        walk_rd_next   = walk_rd_reg;
        eval_v_next    = eval_v_reg;
        eval_addr_next = eval_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        fired_next     = fired_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[AW-1:0];
        wr_entry       = cur;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next       = opcode_t'(opcode);
                    idx_next      = timer_index;
                    typ_next      = timer_type;
                    tval_next     = timeout_value;
                    tval_sec_next = tval_prod[31:0];
                    ack_ok_next   = !(opcode_t'(opcode) == OP_CREATE && !idx_in_range);
                    if (opcode_t'(opcode) == OP_TICK)
                    begin
                        cur_time_next  = now_ms;
                        prev_tick_next = now_ms;
                        walk_rd_next   = '0;
                        eval_v_next    = 1'b0;
                        state_next     = (now_ms != prev_tick_reg) ? ST_WALK : ST_ACK;
                    end
                    else
                    begin
                        state_next = idx_in_range ? ST_RD : ST_ACK;
                    end
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_MOD;
            end

            ST_MOD:
            begin
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (!cur.created)
                        begin
                            wr_en            = 1'b1;
                            wr_entry.created = 1'b1;
                            wr_entry.ttype   = typ_reg;
                            wr_entry.timeout = '0;
                            wr_entry.start   = '0;
                        end
                    end
                    OP_START:
                    begin
                        wr_en            = 1'b1;
                        wr_entry.timeout = is_sec_type(cur.ttype) ? tval_sec_reg : tval_reg;
                        wr_entry.start   = cur_time_reg;
                    end
                    OP_STOP:
                    begin
                        wr_en            = 1'b1;
                        wr_entry.timeout = '0;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
                state_next = ST_ACK;
            end

            ST_WALK:
            begin
                // read of slot k+1 overlaps write-back of slot k
                if (!emit || out_free)
                begin
                    if (eval_v_reg && expired)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = eval_addr_reg;
                        if (is_periodic(cur.ttype))
                            wr_entry.start = cur_time_reg;
                        else
                            wr_entry.timeout = '0;
                    end
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_EXPIRY;
                        fired_next     = 4'(eval_addr_reg);
                        ok_next        = 1'b1;
                        last_next      = 1'b0;
                    end
                    if (walk_rd_reg != WALK_END)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = walk_rd_reg[AW-1:0];
                        eval_addr_next = walk_rd_reg[AW-1:0];
                        eval_v_next    = 1'b1;
                        walk_rd_next   = walk_rd_reg + 1'b1;
                    end
                    else
                    begin
                        eval_v_next = 1'b0;
                        state_next  = ST_ACK;
                    end
                end
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACK;
                    fired_next     = '0;
                    ok_next        = ack_ok_reg;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_tick_reg <= '0;
            cur_time_reg  <= '0;
            walk_rd_reg   <= '0;
            eval_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_tick_reg <= prev_tick_next;
            cur_time_reg  <= cur_time_next;
            walk_rd_reg   <= walk_rd_next;
            eval_v_reg    <= eval_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        typ_reg       <= typ_next;
        tval_reg      <= tval_next;
        tval_sec_reg  <= tval_sec_next;
        ack_ok_reg    <= ack_ok_next;
        eval_addr_reg <= eval_addr_next;
        kind_reg      <= kind_next;
        fired_reg     <= fired_next;
        ok_reg        <= ok_next;
        last_reg      <= last_next;
    end

    // slot memory: one read, one write per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_entry;
        if (rd_en)
            rd_entry_reg <= mem[rd_addr];
    end

    // an entry never written reads as the reset slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // read and write-back of the walk never touch the same slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("slot read and write collide");

    // nothing left under evaluation once the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !eval_v_reg)
    else $error("walk left a slot pending");

    // walk pointer stays within the bank
    assert property (@(posedge clk) disable iff (!rst_n)
        walk_rd_reg <= WALK_END)
    else $error("walk pointer beyond bank");

    // an expiry is only ever produced during a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) && out_valid_next && (kind_next == KIND_EXPIRY)
        |-> (state_reg == ST_WALK))
    else $error("expiry outside tick walk");

endmodule

### tb/multi_channel_soft_timer_bank_top_test.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_bank_top_test
// Checks the timer bank against a cycle-free model of its slots.
// A short table of directed operations comes first. Seconds and millisecond
// types, timeout wrap, uncreated slots, out-of-range slots and repeated tick
// times are all covered there. Random traffic follows in three idling
// phases. Each phase holds one volley that arms all sixteen slots and fires
// them on a single tick. Every result is compared field by field with the
// model's queue.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_bank_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mcstb_pkg::*;

    localparam int NUM_TIMERS   = 16;
    localparam int NUM_DIRECTED = 25;
    localparam int PHASE_ITEMS  = 67;
    localparam int STALL_CYCLES = 400;

    localparam logic [1:0] TT_SEC_ONESHOT  = 2'd0;
    localparam logic [1:0] TT_MS_ONESHOT   = 2'd1;
    localparam logic [1:0] TT_SEC_PERIODIC = 2'd2;
    localparam logic [1:0] TT_MS_PERIODIC  = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [3:0] fired;
        logic       ok;
        logic       last;
    } timer_result_t;

    // typed set: the row carries its own acknowledge instead of the model's
    typedef struct packed {
        opcode_t     op;
        logic [4:0]  idx;
        logic [1:0]  ttype;
        logic [31:0] tval;
        logic [31:0] now;
        logic        typed;
        logic        typed_ok;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_CREATE, 5'd16, TT_SEC_ONESHOT,  32'd0,          32'd0,          1'b1, 1'b0},
        '{OP_CREATE, 5'd31, TT_MS_PERIODIC,  32'd0,          32'd0,          1'b1, 1'b0},
        '{OP_CREATE, 5'd0,  TT_SEC_ONESHOT,  32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_CREATE, 5'd0,  TT_MS_PERIODIC,  32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_CREATE, 5'd15, TT_MS_PERIODIC,  32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_CREATE, 5'd1,  TT_MS_ONESHOT,   32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_CREATE, 5'd2,  TT_SEC_PERIODIC, 32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_START,  5'd0,  2'd0,            32'd2,          32'd0,          1'b1, 1'b1},
        '{OP_START,  5'd15, 2'd0,            32'd5,          32'd0,          1'b1, 1'b1},
        '{OP_START,  5'd1,  2'd0,            32'hFFFF_FFFF,  32'd0,          1'b1, 1'b1},
        // seconds timeout that wraps to zero once scaled: slot stays stopped
        '{OP_START,  5'd2,  2'd0,            32'h2000_0000,  32'd0,          1'b1, 1'b1},
        // never created: runs and stops silently
        '{OP_START,  5'd3,  2'd0,            32'd1,          32'd0,          1'b1, 1'b1},
        '{OP_START,  5'd20, 2'd0,            32'hFFFF_FFFF,  32'd0,          1'b1, 1'b1},
        '{OP_STOP,   5'd31, 2'd0,            32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd5,          1'b0, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd5,          1'b1, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd1000,       1'b0, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd2000,       1'b0, 1'b1},
        '{OP_STOP,   5'd15, 2'd0,            32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'hFFFF_FFFF,  1'b0, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd0,          1'b0, 1'b1},
        '{OP_CREATE, 5'd4,  TT_MS_PERIODIC,  32'd0,          32'd0,          1'b1, 1'b1},
        '{OP_START,  5'd4,  2'd0,            32'd1,          32'd0,          1'b1, 1'b1},
        '{OP_TICK,   5'd0,  2'd0,            32'd0,          32'd1,          1'b0, 1'b1}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [4:0]  timer_index;
    logic [1:0]  timer_type;
    logic [31:0] timeout_value;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [3:0]  fired_timer;
    logic        ok;
    logic        last;

    // model state
    slot_t       bank_model [NUM_TIMERS];
    logic [31:0] model_now;
    logic [31:0] model_prev_tick;

    timer_result_t step_results [$];
    timer_result_t pending_results [$];

    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    bit stall_req;

    multi_channel_soft_timer_bank_top #(
        .NUM_TIMERS (NUM_TIMERS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .timer_index   (timer_index),
        .timer_type    (timer_type),
        .timeout_value (timeout_value),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .fired_timer   (fired_timer),
        .ok            (ok),
        .last          (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one operation to the model; results land in step_results
    function automatic void timer_bank_step(input opcode_t op, input logic [4:0] idx,
                                            input logic [1:0] ttype,
                                            input logic [31:0] tval,
                                            input logic [31:0] now);
        logic        ack_ok;
        logic        in_range;
        logic [31:0] elapsed;
        logic [1:0]  slot_ty;
        ack_ok   = 1'b1;
        in_range = int'(idx) < NUM_TIMERS;
        step_results.delete();
        case (op)
            OP_TICK:
            begin
                model_now = now;
                if (model_prev_tick != model_now)
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        elapsed = model_now - bank_model[i].start;
                        if (bank_model[i].timeout != 32'd0 &&
                            elapsed >= bank_model[i].timeout)
                        begin
                            if (bank_model[i].created)
                                step_results.push_back('{KIND_EXPIRY, 4'(i), 1'b1, 1'b0});
                            if (bank_model[i].ttype == TT_SEC_PERIODIC ||
                                bank_model[i].ttype == TT_MS_PERIODIC)
                                bank_model[i].start = model_now;
                            else
                                bank_model[i].timeout = 32'd0;
                        end
                    end
                end
                model_prev_tick = model_now;
            end
            OP_CREATE:
            begin
                if (!in_range)
                    ack_ok = 1'b0;
                else if (!bank_model[idx[3:0]].created)
                    bank_model[idx[3:0]] = '{1'b1, ttype, 32'd0, 32'd0};
            end
            OP_START:
            begin
                if (in_range)
                begin
                    slot_ty = bank_model[idx[3:0]].ttype;
                    if (slot_ty == TT_SEC_ONESHOT || slot_ty == TT_SEC_PERIODIC)
                        bank_model[idx[3:0]].timeout = tval * 32'(MS_PER_SEC);
                    else
                        bank_model[idx[3:0]].timeout = tval;
                    bank_model[idx[3:0]].start = model_now;
                end
            end
            default:
            begin
                if (in_range)
                    bank_model[idx[3:0]].timeout = 32'd0;
            end
        endcase
        step_results.push_back('{KIND_ACK, 4'd0, ack_ok, 1'b1});
    endfunction

    task automatic send_item(input opcode_t op, input logic [4:0] idx,
                             input logic [1:0] ttype, input logic [31:0] tval,
                             input logic [31:0] now, input logic typed,
                             input logic typed_ok);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        timer_index   <= idx;
        timer_type    <= ttype;
        timeout_value <= tval;
        now_ms        <= now;
        do
            @(posedge clk);
        while (!in_ready);
        timer_bank_step(op, idx, ttype, tval, now);
        if (typed)
            pending_results.push_back('{KIND_ACK, 4'd0, typed_ok, 1'b1});
        else
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d timer %0d ok %0d last %0d",
                         $time, kind, fired_timer, ok, last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 4'(want.kind), 4'(kind));
                check_field("fired_timer", want.fired, fired_timer);
                check_field("ok", 4'(want.ok), 4'(ok));
                check_field("last", 4'(want.last), 4'(last));
            end
        end
    end

    // receiver; one long hold-off on request so the bank backs up
    initial
    begin : receiver
        int  hold_left;
        bit  stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req && !stall_done)
            begin
                hold_left  = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("[multi_channel_soft_timer_bank_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        opcode_t     r_op;
        logic [4:0]  r_idx;
        logic [1:0]  r_type;
        logic [31:0] r_tval;
        logic [31:0] r_now;
        int          sel;
        int          volley_at;
        stim_row_t   row;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        opcode          = OP_TICK;
        timer_index     = 5'd0;
        timer_type      = 2'd0;
        timeout_value   = 32'd0;
        now_ms          = 32'd0;
        mismatches      = 0;
        stall_req       = 1'b0;
        send_idle_pct   = 20;
        recv_idle_pct   = 87;
        model_now       = 32'd0;
        model_prev_tick = 32'd0;
        foreach (bank_model[i])
            bank_model[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[r])
        begin
            row = DIRECTED_ROWS[r];
            send_item(row.op, row.idx, row.ttype, row.tval, row.now, row.typed, row.typed_ok);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 87 : 0;
            recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 20 : 0;
            if (ph == 2)
                stall_req = 1'b1;
            volley_at = $urandom_range(50, 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // volley: every slot armed, then one tick fires all sixteen
                if (n == volley_at)
                begin
                    for (int s = 0; s < NUM_TIMERS; s++)
                        send_item(OP_CREATE, 5'(s), 2'($urandom_range(3)), 32'd0, 32'd0,
                                  1'b0, 1'b1);
                    for (int s = 0; s < NUM_TIMERS; s++)
                        send_item(OP_START, 5'(s), 2'd0, 32'd1, 32'd0, 1'b0, 1'b1);
                    send_item(OP_TICK, 5'd0, 2'd0, 32'd0, model_now + 32'd1000, 1'b0, 1'b1);
                end

                sel = $urandom_range(99);
                if (sel < 40)
                    r_op = OP_TICK;
                else if (sel < 55)
                    r_op = OP_CREATE;
                else if (sel < 85)
                    r_op = OP_START;
                else
                    r_op = OP_STOP;

                r_idx  = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 16))
                                                  : 5'($urandom_range(15));
                r_type = 2'($urandom_range(3));

                sel = $urandom_range(9);
                if (sel == 0)
                    r_tval = 32'd0;
                else if (sel == 1)
                    r_tval = $urandom();
                else if (sel == 2)
                    r_tval = {3'($urandom_range(7)), 29'd0};
                else
                    r_tval = 32'($urandom_range(12, 1));

                sel = $urandom_range(9);
                if (sel == 0)
                    r_now = model_prev_tick;
                else if (sel == 1)
                    r_now = $urandom();
                else if (sel < 4)
                    r_now = model_now + 32'($urandom_range(1500, 900));
                else
                    r_now = model_now + 32'($urandom_range(6, 1));

                send_item(r_op, r_idx, r_type, r_tval, r_now, 1'b0, 1'b1);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("[multi_channel_soft_timer_bank_top] OK");
        else
            $display("[multi_channel_soft_timer_bank_top] ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/mcstb_pkg.sv
hw/rtl/multi_channel_soft_timer_bank_top.sv
tb/multi_channel_soft_timer_bank_top_test.sv
